// ===== rtl/pcu_pkg.sv =====
// Shared types and constants of the per-core utilization block.
`default_nettype none

package pcu_pkg;

   localparam int MaxCores = 64;
   localparam int CoreAw   = (MaxCores > 1) ? $clog2(MaxCores) : 1;
   localparam int CoreW    = 6;
   localparam int CtrW     = 64;
   localparam int TotW     = CtrW + 1;
   localparam int ShareW   = 14;
   localparam int LoW      = 32;
   localparam int HiW      = TotW - LoW;
   localparam int NumW     = TotW + ShareW;
   localparam int DivCntW  = $clog2(ShareW + 1);

   localparam logic [ShareW-1:0] ShareFull = 14'd10000;

   // register index decode (byte address bit 2)
   localparam logic RegShowIdx = 1'b0;

   typedef struct packed {
      logic [CtrW-1:0] idle;
      logic [CtrW-1:0] kernel;
      logic [CtrW-1:0] user;
      logic [CtrW-1:0] dpc;
      logic [CtrW-1:0] irq;
   } snap_type;

   typedef enum logic [1:0] {
      KIND_BUSY = 2'd0,
      KIND_DPC  = 2'd1,
      KIND_IRQ  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_TOTAL,
      ST_BUSY,
      ST_DIV,
      ST_WAIT,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_CHECK,
      DIV_SCALE,
      DIV_RUN
   } div_state_type;

   typedef struct packed {
      logic            start;
      logic [TotW-1:0] part;
      logic [TotW-1:0] total;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [ShareW-1:0] share;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/pcu_snap_mem.sv =====
// Previous-snapshot store: one entry per core, registered read port.
`default_nettype none

module pcu_snap_mem (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [pcu_pkg::CoreAw-1:0] wr_addr,
   input  wire pcu_pkg::snap_type          wr_data,
   input  wire logic                       rd_en,
   input  wire logic [pcu_pkg::CoreAw-1:0] rd_addr,
   output pcu_pkg::snap_type               rd_data
);

   pcu_pkg::snap_type mem [pcu_pkg::MaxCores];
   pcu_pkg::snap_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/pcu_share_div.sv =====
// Share unit: floor(part * 10000 / total), saturated, restoring division.
`default_nettype none

module pcu_share_div (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire pcu_pkg::div_req_type req,
   output pcu_pkg::div_rsp_type rsp
);

   localparam int PloW = pcu_pkg::LoW + pcu_pkg::ShareW;
   localparam int PhiW = pcu_pkg::HiW + pcu_pkg::ShareW;

   pcu_pkg::div_state_type dstate_ff, dstate_in;

   logic [pcu_pkg::TotW-1:0]    part_ff;
   logic [pcu_pkg::TotW-1:0]    total_ff;
   logic [PloW-1:0]             plo_ff;
   logic [PhiW-1:0]             phi_ff;
   logic [pcu_pkg::TotW-1:0]    rem_ff;
   logic [pcu_pkg::ShareW-1:0]  quo_ff;
   logic [pcu_pkg::DivCntW-1:0] cnt_ff;
   logic [pcu_pkg::ShareW-1:0]  share_ff;
   logic                        done_ff;

   logic [pcu_pkg::NumW-1:0]    num;
   logic [pcu_pkg::TotW:0]      trial;
   logic [pcu_pkg::TotW:0]      trial_diff;
   logic                        fits;
   logic [pcu_pkg::ShareW-1:0]  quo_in;

   // scaled numerator from the two registered partial products
   assign num = {{(pcu_pkg::NumW-PloW){1'b0}}, plo_ff}
              + {phi_ff, {pcu_pkg::LoW{1'b0}}};

   assign trial      = {rem_ff, quo_ff[pcu_pkg::ShareW-1]};
   assign trial_diff = trial - {1'b0, total_ff};
   assign fits       = (trial >= {1'b0, total_ff});
   assign quo_in     = {quo_ff[pcu_pkg::ShareW-2:0], fits};

   always_comb begin
      dstate_in = dstate_ff;
      case (dstate_ff)
         pcu_pkg::DIV_IDLE: begin
            if (req.start) begin
               dstate_in = pcu_pkg::DIV_CHECK;
            end
         end
         pcu_pkg::DIV_CHECK: begin
            if ((total_ff == '0) || (part_ff >= total_ff)) begin
               dstate_in = pcu_pkg::DIV_IDLE;
            end else begin
               dstate_in = pcu_pkg::DIV_SCALE;
            end
         end
         pcu_pkg::DIV_SCALE: begin
            dstate_in = pcu_pkg::DIV_RUN;
         end
         pcu_pkg::DIV_RUN: begin
            if (cnt_ff == pcu_pkg::DivCntW'(1)) begin
               dstate_in = pcu_pkg::DIV_IDLE;
            end
         end
         default: begin
            dstate_in = pcu_pkg::DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dstate_ff <= pcu_pkg::DIV_IDLE;
         done_ff   <= 1'b0;
      end else begin
         dstate_ff <= dstate_in;
         done_ff   <= 1'b0;
         case (dstate_ff)
            pcu_pkg::DIV_CHECK: begin
               if ((total_ff == '0) || (part_ff >= total_ff)) begin
                  done_ff <= 1'b1;
               end
            end
            pcu_pkg::DIV_RUN: begin
               if (cnt_ff == pcu_pkg::DivCntW'(1)) begin
                  done_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (dstate_ff)
         pcu_pkg::DIV_IDLE: begin
            if (req.start) begin
               part_ff  <= req.part;
               total_ff <= req.total;
            end
         end
         pcu_pkg::DIV_CHECK: begin
            if (total_ff == '0) begin
               share_ff <= '0;
            end else if (part_ff >= total_ff) begin
               share_ff <= pcu_pkg::ShareFull;
            end
            plo_ff <= PloW'(part_ff[pcu_pkg::LoW-1:0]) * PloW'(pcu_pkg::ShareFull);
            phi_ff <= PhiW'(part_ff[pcu_pkg::TotW-1:pcu_pkg::LoW])
                    * PhiW'(pcu_pkg::ShareFull);
         end
         pcu_pkg::DIV_SCALE: begin
            // part < total, so the top of the numerator is already below total
            rem_ff <= num[pcu_pkg::NumW-1:pcu_pkg::ShareW];
            quo_ff <= num[pcu_pkg::ShareW-1:0];
            cnt_ff <= pcu_pkg::DivCntW'(pcu_pkg::ShareW);
         end
         pcu_pkg::DIV_RUN: begin
            rem_ff <= fits ? trial_diff[pcu_pkg::TotW-1:0] : trial[pcu_pkg::TotW-1:0];
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - pcu_pkg::DivCntW'(1);
            if (cnt_ff == pcu_pkg::DivCntW'(1)) begin
               share_ff <= quo_in;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp.done  = done_ff;
   assign rsp.share = share_ff;

endmodule

`default_nettype wire

// ===== rtl/per_core_utilization_from_deltas.sv =====
// Per-core utilization from cumulative time counter deltas: top level.
// Steps from request to first result: read, total, busy, then per share start, check,
// scale, 14 quotient steps, done, load; a zero or saturated share skips scale and the
// quotient steps. A new request is taken only once the last one is through, since the
// single iterative divider serves every share; output stalls hold it back further.
// Reset clears the seen marks, the register and all control; the store is not cleared.
`default_nettype none

module per_core_utilization_from_deltas (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [pcu_pkg::CoreW-1:0]   req_core,
   input  wire logic [pcu_pkg::CtrW-1:0]    req_stamp,
   input  wire logic [pcu_pkg::CtrW-1:0]    req_idle_time,
   input  wire logic [pcu_pkg::CtrW-1:0]    req_kernel_time,
   input  wire logic [pcu_pkg::CtrW-1:0]    req_user_time,
   input  wire logic [pcu_pkg::CtrW-1:0]    req_dpc_time,
   input  wire logic [pcu_pkg::CtrW-1:0]    req_irq_time,
   // result channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [pcu_pkg::CtrW-1:0]         rsp_stamp_out,
   output logic [pcu_pkg::CoreW-1:0]        rsp_core_out,
   output logic [1:0]                       rsp_kind,
   output logic [pcu_pkg::ShareW-1:0]       rsp_share,
   output logic                             rsp_last,
   // configuration port
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [2:0]                  csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   pcu_pkg::state_type state_ff, state_in;

   // configuration
   logic show_ff;

   // captured request
   logic [pcu_pkg::CoreW-1:0]   core_ff;
   logic [pcu_pkg::CtrW-1:0]    stamp_ff;
   pcu_pkg::snap_type           snap_ff;
   logic [pcu_pkg::CoreAw-1:0]  addr;
   logic [pcu_pkg::CoreAw-1:0]  req_addr;

   // seen marks, one flop per core
   logic [pcu_pkg::MaxCores-1:0] seen_ff;

   // deltas and derived totals
   logic [pcu_pkg::CtrW-1:0] kd_ff, ud_ff, id_ff, dd_ff, rd_ff;
   logic [pcu_pkg::TotW-1:0] total_ff;
   logic [pcu_pkg::TotW-1:0] busy_ff;
   pcu_pkg::kind_type        kind_ff;

   // output register
   logic                         rsp_valid_ff;
   logic [pcu_pkg::CtrW-1:0]     rsp_stamp_ff;
   logic [pcu_pkg::CoreW-1:0]    rsp_core_ff;
   pcu_pkg::kind_type            rsp_kind_ff;
   logic [pcu_pkg::ShareW-1:0]   rsp_share_ff;
   logic                         rsp_last_ff;

   // memory and divider hookup
   pcu_pkg::snap_type    mem_rd_data;
   pcu_pkg::div_req_type div_req;
   pcu_pkg::div_rsp_type div_rsp;

   // strobes from the sequencer
   logic accept;
   logic in_range;
   logic mem_wr;
   logic div_start;
   logic out_load;
   logic is_last;
   logic csr_wr;
   logic [pcu_pkg::TotW-1:0] part;
   logic [pcu_pkg::TotW-1:0] total_sum;
   logic [pcu_pkg::TotW-1:0] idle_wide;

   assign req_addr = pcu_pkg::CoreAw'(req_core);
   assign addr     = pcu_pkg::CoreAw'(core_ff);
   assign in_range = (32'(req_core) < pcu_pkg::MaxCores);

   assign req_ready = (state_ff == pcu_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   // final result: interrupt share, or busy when the extra shares are off
   assign is_last = (kind_ff == pcu_pkg::KIND_IRQ) || !show_ff;

   assign total_sum = {1'b0, kd_ff} + {1'b0, ud_ff};
   assign idle_wide = {1'b0, id_ff};

   always_comb begin
      case (kind_ff)
         pcu_pkg::KIND_BUSY: part = busy_ff;
         pcu_pkg::KIND_DPC:  part = {1'b0, dd_ff};
         pcu_pkg::KIND_IRQ:  part = {1'b0, rd_ff};
         default:            part = '0;
      endcase
   end

   // sequencer: read old snapshot, write new one, then one divide per share
   always_comb begin
      state_in  = state_ff;
      mem_wr    = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         pcu_pkg::ST_IDLE: begin
            if (accept && in_range) begin
               state_in = pcu_pkg::ST_READ;
            end
         end
         pcu_pkg::ST_READ: begin
            // old entry is already in the read register, so the write is safe
            mem_wr   = 1'b1;
            state_in = seen_ff[addr] ? pcu_pkg::ST_TOTAL : pcu_pkg::ST_IDLE;
         end
         pcu_pkg::ST_TOTAL: begin
            state_in = pcu_pkg::ST_BUSY;
         end
         pcu_pkg::ST_BUSY: begin
            state_in = pcu_pkg::ST_DIV;
         end
         pcu_pkg::ST_DIV: begin
            div_start = 1'b1;
            state_in  = pcu_pkg::ST_WAIT;
         end
         pcu_pkg::ST_WAIT: begin
            if (div_rsp.done) begin
               state_in = pcu_pkg::ST_EMIT;
            end
         end
         pcu_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = is_last ? pcu_pkg::ST_IDLE : pcu_pkg::ST_DIV;
            end
         end
         default: begin
            state_in = pcu_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcu_pkg::ST_IDLE;
         seen_ff      <= '0;
         show_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (mem_wr) begin
            seen_ff[addr] <= 1'b1;
         end
         if (csr_wr) begin
            show_ff <= csr_pwdata[0];
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         core_ff        <= req_core;
         stamp_ff       <= req_stamp;
         snap_ff.idle   <= req_idle_time;
         snap_ff.kernel <= req_kernel_time;
         snap_ff.user   <= req_user_time;
         snap_ff.dpc    <= req_dpc_time;
         snap_ff.irq    <= req_irq_time;
      end
      if (state_ff == pcu_pkg::ST_READ) begin
         // deltas wrap modulo 2^64
         kd_ff   <= snap_ff.kernel - mem_rd_data.kernel;
         ud_ff   <= snap_ff.user   - mem_rd_data.user;
         id_ff   <= snap_ff.idle   - mem_rd_data.idle;
         dd_ff   <= snap_ff.dpc    - mem_rd_data.dpc;
         rd_ff   <= snap_ff.irq    - mem_rd_data.irq;
         kind_ff <= pcu_pkg::KIND_BUSY;
      end
      if (state_ff == pcu_pkg::ST_TOTAL) begin
         total_ff <= total_sum;
      end
      if (state_ff == pcu_pkg::ST_BUSY) begin
         // busy floors at zero
         busy_ff <= (idle_wide >= total_ff) ? '0 : (total_ff - idle_wide);
      end
      if (out_load) begin
         rsp_stamp_ff <= stamp_ff;
         rsp_core_ff  <= core_ff;
         rsp_kind_ff  <= kind_ff;
         rsp_share_ff <= div_rsp.share;
         rsp_last_ff  <= is_last;
         case (kind_ff)
            pcu_pkg::KIND_BUSY: kind_ff <= pcu_pkg::KIND_DPC;
            pcu_pkg::KIND_DPC:  kind_ff <= pcu_pkg::KIND_IRQ;
            default:            kind_ff <= pcu_pkg::KIND_BUSY;
         endcase
      end
   end

   pcu_snap_mem u_snap_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (addr),
      .wr_data (snap_ff),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (mem_rd_data)
   );

   assign div_req.start = div_start;
   assign div_req.part  = part;
   assign div_req.total = total_ff;

   pcu_share_div u_share_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // result port
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_stamp_out = rsp_stamp_ff;
   assign rsp_core_out  = rsp_core_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_share     = rsp_share_ff;
   assign rsp_last      = rsp_last_ff;

   // register port: one register, word at byte address 0
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == pcu_pkg::RegShowIdx);
   assign csr_prdata = (csr_paddr[2] == pcu_pkg::RegShowIdx) ? {31'b0, show_ff} : 32'b0;

`ifndef ASSERT_OFF
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == pcu_pkg::ST_WAIT))
      else $error("divider result with no share pending");

   a_share_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_share <= pcu_pkg::ShareFull))
      else $error("share above full scale");

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      (accept && in_range) |=> (state_ff == pcu_pkg::ST_READ))
      else $error("accepted request did not start a snapshot read");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |->
         ((rsp_kind == pcu_pkg::KIND_IRQ) || (rsp_kind == pcu_pkg::KIND_BUSY && !show_ff)))
      else $error("last mark on wrong share");
`endif

endmodule

`default_nettype wire

// ===== bench/pcu_share_checker.sv =====
// Checker: predicts the utilization shares of every request and compares each result.
module pcu_share_checker
   import pcu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic [CoreW-1:0]  req_core,
   input  wire logic [CtrW-1:0]   req_stamp,
   input  wire logic [CtrW-1:0]   req_idle_time,
   input  wire logic [CtrW-1:0]   req_kernel_time,
   input  wire logic [CtrW-1:0]   req_user_time,
   input  wire logic [CtrW-1:0]   req_dpc_time,
   input  wire logic [CtrW-1:0]   req_irq_time,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [CtrW-1:0]   rsp_stamp_out,
   input  wire logic [CoreW-1:0]  rsp_core_out,
   input  wire logic [1:0]        rsp_kind,
   input  wire logic [ShareW-1:0] rsp_share,
   input  wire logic              rsp_last,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [2:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   input  wire logic              csr_pready,
   output int                     mismatch_count,
   output int                     awaited_count
);

   typedef struct packed {
      logic [CtrW-1:0]   stamp;
      logic [CoreW-1:0]  core;
      kind_type          kind;
      logic [ShareW-1:0] share;
      logic              last;
   } share_result_type;

   share_result_type expected_shares[$];
   snap_type         held_snap [MaxCores];
   logic             core_seen [MaxCores];
   logic             show_split;

   initial begin
      mismatch_count = 0;
      awaited_count  = 0;
   end

   // floor(part * 10000 / total), exact; full share once part reaches total
   function automatic logic [ShareW-1:0] interval_share(input logic [TotW-1:0] part,
                                                        input logic [TotW-1:0] total);
      logic [NumW-1:0] scaled;
      if (total == '0) begin
         return '0;
      end
      if (part >= total) begin
         return ShareFull;
      end
      scaled = NumW'(part) * NumW'(ShareFull);
      return ShareW'(scaled / NumW'(total));
   endfunction

   task automatic predict_shares(input logic [CoreW-1:0] core, input logic [CtrW-1:0] stamp,
                                 input snap_type fresh);
      snap_type         delta;
      logic [TotW-1:0]  total;
      logic [TotW-1:0]  busy;
      share_result_type item;
      if (core_seen[core]) begin
         delta.idle   = fresh.idle   - held_snap[core].idle;
         delta.kernel = fresh.kernel - held_snap[core].kernel;
         delta.user   = fresh.user   - held_snap[core].user;
         delta.dpc    = fresh.dpc    - held_snap[core].dpc;
         delta.irq    = fresh.irq    - held_snap[core].irq;
         total = {1'b0, delta.kernel} + {1'b0, delta.user};
         busy  = ({1'b0, delta.idle} >= total) ? '0 : total - {1'b0, delta.idle};
         item.stamp = stamp;
         item.core  = core;
         item.kind  = KIND_BUSY;
         item.share = interval_share(busy, total);
         item.last  = !show_split;
         expected_shares.push_back(item);
         if (show_split) begin
            item.kind  = KIND_DPC;
            item.share = interval_share({1'b0, delta.dpc}, total);
            item.last  = 1'b0;
            expected_shares.push_back(item);
            item.kind  = KIND_IRQ;
            item.share = interval_share({1'b0, delta.irq}, total);
            item.last  = 1'b1;
            expected_shares.push_back(item);
         end
      end
      held_snap[core] = fresh;
      core_seen[core] = 1'b1;
   endtask

   function automatic void note_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
      if (want !== got) begin
         $error("result mismatch on %s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic check_share(input logic [CtrW-1:0] stamp, input logic [CoreW-1:0] core,
                              input logic [1:0] kind, input logic [ShareW-1:0] share,
                              input logic last);
      share_result_type want;
      if (expected_shares.size() == 0) begin
         $error("unexpected result: core %0d kind %0d share %0d", core, kind, share);
         mismatch_count++;
      end else begin
         want = expected_shares.pop_front();
         note_field("stamp_out", want.stamp, stamp);
         note_field("core_out", 64'(want.core), 64'(core));
         note_field("kind", 64'(want.kind), 64'(kind));
         note_field("share", 64'(want.share), 64'(share));
         note_field("last", 64'(want.last), 64'(last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_shares.delete();
         show_split = 1'b0;
         for (int c = 0; c < MaxCores; c++) core_seen[c] = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_share(rsp_stamp_out, rsp_core_out, rsp_kind, rsp_share, rsp_last);
         end
         if (req_valid && req_ready) begin
            predict_shares(req_core, req_stamp, '{req_idle_time, req_kernel_time,
                                                  req_user_time, req_dpc_time, req_irq_time});
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == RegShowIdx) begin
            show_split = csr_pwdata[0];
         end
      end
      awaited_count = expected_shares.size();
   end

endmodule

// ===== bench/per_core_utilization_from_deltas_tb.sv =====
// Testbench top: drives counter snapshots, register writes and result backpressure.
module per_core_utilization_from_deltas_tb;
   import pcu_pkg::*;

   // Hang guard: the limit leaves a wide margin over the slowest legal run.
   localparam int CycleLimit   = 600000;
   // A first snapshot gives no result, so the block may still be busy once the
   // last result is in; this covers a full three-share request.
   localparam int SettleCycles = 80;
   localparam logic [CtrW-1:0] AllOnes = {CtrW{1'b1}};
   // Byte addresses: the one register, and a slot past the end of the map.
   localparam logic [2:0] ShowAddr  = {RegShowIdx, 2'b00};
   localparam logic [2:0] SpareAddr = {~RegShowIdx, 2'b00};

   logic              clock = 1'b0;
   logic              reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CoreW-1:0]  req_core = '0;
   logic [CtrW-1:0]   req_stamp = '0;
   logic [CtrW-1:0]   req_idle_time = '0;
   logic [CtrW-1:0]   req_kernel_time = '0;
   logic [CtrW-1:0]   req_user_time = '0;
   logic [CtrW-1:0]   req_dpc_time = '0;
   logic [CtrW-1:0]   req_irq_time = '0;

   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CtrW-1:0]   rsp_stamp_out;
   logic [CoreW-1:0]  rsp_core_out;
   logic [1:0]        rsp_kind;
   logic [ShareW-1:0] rsp_share;
   logic              rsp_last;

   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [2:0]        csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   int                mismatch_count;
   int                awaited_count;
   int                cycle_count = 0;

   // calm: no idling on either side while set
   logic              calm = 1'b0;
   // running cumulative counters per core, as the OS would report them
   snap_type          tally [MaxCores];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   per_core_utilization_from_deltas DUT (.*);

   pcu_share_checker share_check (.*);

   // Receiver backpressure: ready drops in about a quarter of the cycles.
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 24);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("** per_core_utilization_from_deltas: FAILED **");
         $finish;
      end
   end

   function automatic logic [CtrW-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // random value of random bit length, so small and huge deltas both show up
   function automatic logic [CtrW-1:0] rand_span();
      int bits;
      bits = $urandom_range(64, 0);
      return (bits == 0) ? '0 : rand64() >> (64 - bits);
   endfunction

   // APB write: setup cycle then access cycle; pready is tied high in the block.
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Present the current tally of a core as one request. Called at a falling
   // edge; returns at the falling edge after acceptance with valid still high,
   // so back-to-back requests keep valid asserted.
   task automatic send_request(input logic [CoreW-1:0] core, input logic [CtrW-1:0] stamp);
      while (!calm && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_core        <= core;
      req_stamp       <= stamp;
      req_idle_time   <= tally[core].idle;
      req_kernel_time <= tally[core].kernel;
      req_user_time   <= tally[core].user;
      req_dpc_time    <= tally[core].dpc;
      req_irq_time    <= tally[core].irq;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      @(negedge clock);
   endtask

   // Move a core's counters forward by the given deltas (mod 2^64) and send.
   task automatic advance_core(input logic [CoreW-1:0] core, input snap_type delta,
                               input logic [CtrW-1:0] stamp);
      tally[core].idle   += delta.idle;
      tally[core].kernel += delta.kernel;
      tally[core].user   += delta.user;
      tally[core].dpc    += delta.dpc;
      tally[core].irq    += delta.irq;
      send_request(core, stamp);
   endtask

   // Stop sending and wait for every expected result, then let the block go quiet.
   task automatic settle(input int extra);
      req_valid <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   // One random request. Mostly a plausible interval on a handful of busy
   // cores; a tenth are counter jumps to arbitrary values.
   task automatic random_request();
      logic [CoreW-1:0] core;
      snap_type         delta;
      core = ($urandom_range(99) < 70) ? CoreW'($urandom_range(7))
                                       : CoreW'($urandom_range(MaxCores - 1));
      if ($urandom_range(99) < 10) begin
         tally[core] = {rand64(), rand64(), rand64(), rand64(), rand64()};
         send_request(core, rand64());
      end else begin
         delta.kernel = rand_span();
         delta.user   = rand_span();
         case ($urandom_range(9))
            0: delta.idle = rand_span();      // can run past the total: busy floors at 0
            1: delta.idle = delta.kernel;     // idle equal to kernel time; fully idle only when user time is zero
            default: delta.idle = (delta.kernel == '0) ? '0 : rand64() % delta.kernel;
         endcase
         // DPC and interrupt time normally a slice of kernel time, sometimes anything
         delta.dpc = ($urandom_range(3) == 0) ? rand_span()
                                              : rand64() % ({2'b00, delta.kernel[63:2]} + 1);
         delta.irq = ($urandom_range(3) == 0) ? rand_span()
                                              : rand64() % ({2'b00, delta.kernel[63:2]} + 1);
         advance_core(core, delta, rand64());
      end
   endtask

   // A run of random requests, optionally with a no-idle window and one
   // point where the sender holds off until all results are back.
   task automatic random_run(input int count, input int calm_from, input int calm_to,
                             input int pause_at);
      for (int i = 0; i < count; i++) begin
         calm = (i >= calm_from) && (i < calm_to);
         if (i == pause_at) begin
            settle(0);
         end
         random_request();
      end
      calm = 1'b0;
   endtask

   initial begin
      for (int c = 0; c < MaxCores; c++) begin
         tally[c] = {rand64(), rand64(), rand64(), rand64(), rand64()};
      end
      tally[0]  = '0;
      tally[63] = {5{AllOnes}};

      // synchronous reset, released at a falling edge
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed, DPC and interrupt shares enabled ----
      csr_write(ShowAddr, {31'($urandom), 1'b1});
      @(negedge clock);
      // first snapshot of a core is only stored
      advance_core(0, '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0}, '0);
      // zero total: every share is 0
      advance_core(0, '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0}, 64'd1);
      // all-idle interval, interrupt part equal to total saturates
      advance_core(0, '{64'd1000, 64'd1000, 64'd0, 64'd0, 64'd1000}, rand64());
      // kernel plus user overflows 64 bits; exact 65-bit total
      advance_core(0, '{64'd0, AllOnes, AllOnes, AllOnes, 64'd1}, rand64());
      // small fractions; DPC part larger than total saturates
      advance_core(0, '{64'd1, 64'd3, 64'd0, 64'd5, 64'd1}, rand64());
      // idle delta beyond total: busy floors at 0
      advance_core(0, '{AllOnes, 64'd10, 64'd10, 64'd0, 64'd0}, rand64());
      // rounding just under one unit and just under full
      advance_core(0, '{64'd10000, 64'd10001, 64'd0, 64'd10000, 64'd1}, rand64());
      // top core, counters and stamp all ones, then wrap around zero
      advance_core(63, '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0}, AllOnes);
      advance_core(63, '{64'd6, 64'd6, 64'd6, 64'd6, 64'd6}, rand64());
      advance_core(63, '{64'd0, 64'd0, AllOnes, 64'h8000_0000_0000_0000, AllOnes}, rand64());
      advance_core(42, '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0}, rand64());
      advance_core(42, '{64'd1, 64'd2, 64'd1, 64'd1, 64'd0}, rand64());
      settle(SettleCycles);

      // ---- busy share only; a write past the register map must not re-enable ----
      csr_write(ShowAddr, {31'($urandom), 1'b0});
      csr_write(SpareAddr, 32'hFFFF_FFFF);
      @(negedge clock);
      advance_core(0, '{64'd5, 64'd20, 64'd5, 64'd1, 64'd1}, rand64());
      advance_core(63, '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0}, rand64());
      advance_core(42, '{64'd0, AllOnes, AllOnes, 64'd0, 64'd0}, rand64());

      // ---- random phases, alternating the register ----
      random_run(160, -1, -1, -1);
      settle(SettleCycles);
      csr_write(ShowAddr, {31'($urandom), 1'b1});
      @(negedge clock);
      random_run(160, 40, 110, 80);
      settle(SettleCycles);
      csr_write(ShowAddr, {31'($urandom), 1'b0});
      @(negedge clock);
      random_run(80, -1, -1, -1);
      settle(SettleCycles);
      csr_write(ShowAddr, {31'($urandom), 1'b1});
      @(negedge clock);
      random_run(80, -1, -1, -1);

      // drain, then give late or spurious results a chance to show up
      settle(SettleCycles);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("** per_core_utilization_from_deltas: PASSED **");
      end else begin
         $display("** per_core_utilization_from_deltas: FAILED **");
      end
      $finish;
   end

endmodule
